@@ src/mfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared widths, constants and types for the multitap fractional delay core.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // Sample store geometry
  localparam int DEPTH     = 65536;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LEN_W     = ADDR_W + 1;

  // Fixed field widths
  localparam int CFG_W     = 17;
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 8;
  localparam int DELAY_W   = 24;

  // Derived datapath widths
  localparam int POS_W     = LEN_W + FRAC_BITS + 1;   // signed tap position
  localparam int COEF_W    = FRAC_BITS + 2;           // signed blend weight
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 1;

  // Stream payload widths
  localparam int IN_DATA_W  = ((SAMPLE_W + DELAY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

  // Length register limits
  localparam logic [LEN_W-1:0] MIN_LEN       = LEN_W'(2);
  localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(DEPTH);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(48001);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [FRAC_BITS-1:0]       frac_t;

  // Store write request
  typedef struct packed {
    logic    en;
    addr_t   addr;
    sample_t data;
  } store_wr_t;

  // Store dual read request
  typedef struct packed {
    logic  en;
    addr_t addr_a;
    addr_t addr_b;
  } store_rd_t;

endpackage

@@ src/mfd_store.sv @@
// ----------------------------------------------------------------------------
// mfd_store
// Sample memory: one write port, two registered read ports. A fill mark
// makes never-written entries read as zero; same-cycle writes are forwarded.
// ----------------------------------------------------------------------------
module mfd_store (
  input  logic               clk,
  input  logic               rst_n,
  input  mfd_pkg::store_wr_t wr,
  input  mfd_pkg::store_rd_t rd,
  output mfd_pkg::sample_t   rd_a,
  output mfd_pkg::sample_t   rd_b
);

  logic [mfd_pkg::SAMPLE_W-1:0] store_mem [mfd_pkg::DEPTH];

  mfd_pkg::len_t    hwm_r;
  mfd_pkg::len_t    hwm_nxt;
  mfd_pkg::len_t    wr_top;
  mfd_pkg::sample_t raw_a_r;
  mfd_pkg::sample_t raw_b_r;
  mfd_pkg::sample_t fwd_data_r;
  logic             vld_a_r;
  logic             vld_b_r;
  logic             fwd_a_r;
  logic             fwd_b_r;

  // Writes only ever walk upward from entry zero, so the written set is a prefix
  assign wr_top = {1'b0, wr.addr} + mfd_pkg::LEN_W'(1);

  always_comb begin
    hwm_nxt = hwm_r;
    if (wr.en && (wr_top > hwm_r)) begin
      hwm_nxt = wr_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwm_r <= '0;
    end else begin
      hwm_r <= hwm_nxt;
    end
  end

  // Memory array: write, then read-before-write on both read ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      raw_a_r <= store_mem[rd.addr_a];
      raw_b_r <= store_mem[rd.addr_b];
    end
  end

  // Fill-mark and forwarding flags travel with the read data
  always_ff @(posedge clk) begin
    if (rd.en) begin
      vld_a_r    <= ({1'b0, rd.addr_a} < hwm_r);
      vld_b_r    <= ({1'b0, rd.addr_b} < hwm_r);
      fwd_a_r    <= wr.en && (wr.addr == rd.addr_a);
      fwd_b_r    <= wr.en && (wr.addr == rd.addr_b);
      fwd_data_r <= wr.data;
    end
  end

  assign rd_a = fwd_a_r ? fwd_data_r : (vld_a_r ? raw_a_r : '0);
  assign rd_b = fwd_b_r ? fwd_data_r : (vld_b_r ? raw_b_r : '0);

endmodule

@@ src/multitap_fractional_delay_core.sv @@
// ----------------------------------------------------------------------------
// multitap_fractional_delay_core
// Circular delay line with fractional taps read by linear interpolation.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  --------+-----------+-------------------------------------------------
//  in_*    | slave     | tdata: sample_in, tap_delay; tuser: req_type;
//          |           | tlast: last_tap
//  out_*   | master    | tdata: tap_out; tlast: last_flag
//  cfg_*   | write     | cfg_wr_data: max_len (resets write pointer)
//
//  One transaction per cycle sustained while out_tready is high; results
//  pass through the address pipe, the registered store read and the
//  multiply/sum stages to out_tvalid. The store write and both tap reads of an
//  item happen at the same edge, with same-entry writes forwarded.
//  Reset: synchronous, active low; the store needs no clearing pass, as a
//  fill mark makes never-written entries read as zero.
//  Stalls on out_tready back up stage by stage; empty stages still fill.
// ----------------------------------------------------------------------------
module multitap_fractional_delay_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mfd_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] sample_in, [39:16] tap_delay
  input  logic                           in_tuser,   // [0] req_type
  input  logic                           in_tlast,
  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mfd_pkg::OUT_DATA_W-1:0] out_tdata,  // [15:0] tap_out
  output logic                           out_tlast,
  // Configuration
  input  logic                           cfg_wr_en,
  input  logic [mfd_pkg::CFG_W-1:0]      cfg_wr_data
);

  localparam logic [mfd_pkg::FRAC_BITS:0] ONE = (mfd_pkg::FRAC_BITS+1)'(1) << mfd_pkg::FRAC_BITS;

  // Configuration and write pointer
  mfd_pkg::len_t  eff_len_r;
  mfd_pkg::len_t  eff_len_nxt;
  mfd_pkg::addr_t len_m1_r;
  mfd_pkg::addr_t wp_r;
  mfd_pkg::addr_t wp_nxt;
  mfd_pkg::addr_t wp_inc;

  // Stage valids and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;
  logic in_acc;

  // Stage payloads
  logic                          s1_push_r, s2_push_r, s3_push_r, s4_push_r;
  mfd_pkg::sample_t              s1_sample_r, s2_sample_r, s3_sample_r, s4_sample_r;
  logic [mfd_pkg::DELAY_W-1:0]   s1_delay_r;
  logic                          s1_last_r, s2_last_r, s3_last_r, s4_last_r;
  logic                          s5_last_r, s6_last_r;
  mfd_pkg::addr_t                s1_waddr_r, s2_waddr_r, s3_waddr_r, s4_waddr_r;
  mfd_pkg::addr_t                s1_rp_r;
  logic [mfd_pkg::POS_W-1:0]     s2_pos_r;
  mfd_pkg::addr_t                s3_ia_r, s4_ia_r, s4_ib_r;
  mfd_pkg::frac_t                s3_fr_r, s4_fr_r, s5_fr_r;
  logic signed [mfd_pkg::PROD_W-1:0] s6_pa_r, s6_pb_r;
  mfd_pkg::sample_t              out_tap_r;
  logic                          out_last_r;

  // Datapath intermediates
  logic [mfd_pkg::POS_W-1:0]     span;
  logic [mfd_pkg::POS_W-1:0]     rp_fx;
  logic [mfd_pkg::POS_W-1:0]     delay_x;
  logic [mfd_pkg::POS_W-1:0]     delay_sat;
  logic [mfd_pkg::POS_W-1:0]     pos_raw;
  logic [mfd_pkg::POS_W-1:0]     pos_w;
  mfd_pkg::addr_t                ib_calc;
  logic [mfd_pkg::FRAC_BITS:0]   one_m_fr;
  logic signed [mfd_pkg::ACC_W-1:0] acc;

  mfd_pkg::store_wr_t            st_wr;
  mfd_pkg::store_rd_t            st_rd;
  mfd_pkg::sample_t              smp_a;
  mfd_pkg::sample_t              smp_b;

  // Pipeline flow: a stage loads when empty or when it drains this cycle
  assign ld7       = !out_valid_r || out_tready;
  assign ld6       = !v6_r || ld7;
  assign ld5       = !v5_r || ld6;
  assign ld4       = !v4_r || ld5;
  assign ld3       = !v3_r || ld4;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) v1_r        <= in_acc;
      if (ld2) v2_r        <= v1_r;
      if (ld3) v3_r        <= v2_r;
      if (ld4) v4_r        <= v3_r;
      if (ld5) v5_r        <= v4_r;
      if (ld6) v6_r        <= v5_r;
      if (ld7) out_valid_r <= v6_r;
    end
  end

  // Length clamp on configuration write
  always_comb begin
    if (cfg_wr_data < mfd_pkg::CFG_W'(mfd_pkg::MIN_LEN)) begin
      eff_len_nxt = mfd_pkg::MIN_LEN;
    end else if (cfg_wr_data > mfd_pkg::CFG_W'(mfd_pkg::MAX_LEN)) begin
      eff_len_nxt = mfd_pkg::MAX_LEN;
    end else begin
      eff_len_nxt = mfd_pkg::LEN_W'(cfg_wr_data);
    end
  end

  // Write pointer advances on push transactions, wraps at the length
  assign wp_inc = wp_r + mfd_pkg::ADDR_W'(1);

  always_comb begin
    wp_nxt = wp_r;
    if (in_acc && in_tuser) begin
      wp_nxt = (wp_r == len_m1_r) ? '0 : wp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_len_r <= mfd_pkg::MAX_LEN_RESET;
      len_m1_r  <= mfd_pkg::ADDR_W'(mfd_pkg::MAX_LEN_RESET - mfd_pkg::LEN_W'(1));
      wp_r      <= '0;
    end else if (cfg_wr_en) begin
      eff_len_r <= eff_len_nxt;
      len_m1_r  <= mfd_pkg::ADDR_W'(eff_len_nxt - mfd_pkg::LEN_W'(1));
      wp_r      <= '0;
    end else begin
      wp_r      <= wp_nxt;
    end
  end

  // Stage 1: capture transaction and pointers
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_push_r   <= in_tuser;
      s1_sample_r <= in_tdata[mfd_pkg::SAMPLE_W-1:0];
      s1_delay_r  <= in_tdata[mfd_pkg::SAMPLE_W +: mfd_pkg::DELAY_W];
      s1_last_r   <= in_tlast;
      s1_waddr_r  <= wp_r;
      s1_rp_r     <= wp_nxt;
    end
  end

  // Stage 2: saturate delay and subtract from the read pointer
  assign span      = mfd_pkg::POS_W'({eff_len_r, {mfd_pkg::FRAC_BITS{1'b0}}});
  assign rp_fx     = mfd_pkg::POS_W'({s1_rp_r, {mfd_pkg::FRAC_BITS{1'b0}}});
  assign delay_x   = mfd_pkg::POS_W'(s1_delay_r);
  assign delay_sat = (delay_x > span) ? span : delay_x;
  assign pos_raw   = rp_fx - delay_sat;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_pos_r    <= pos_raw;
      s2_push_r   <= s1_push_r;
      s2_sample_r <= s1_sample_r;
      s2_last_r   <= s1_last_r;
      s2_waddr_r  <= s1_waddr_r;
    end
  end

  // Stage 3: wrap negative position, split index and fraction
  assign pos_w = s2_pos_r[mfd_pkg::POS_W-1] ? (s2_pos_r + span) : s2_pos_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_ia_r     <= pos_w[mfd_pkg::FRAC_BITS +: mfd_pkg::ADDR_W];
      s3_fr_r     <= pos_w[mfd_pkg::FRAC_BITS-1:0];
      s3_push_r   <= s2_push_r;
      s3_sample_r <= s2_sample_r;
      s3_last_r   <= s2_last_r;
      s3_waddr_r  <= s2_waddr_r;
    end
  end

  // Stage 4: second neighbor, wrapping to entry zero
  assign ib_calc = (s3_ia_r == len_m1_r) ? '0 : (s3_ia_r + mfd_pkg::ADDR_W'(1));

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_ia_r     <= s3_ia_r;
      s4_ib_r     <= ib_calc;
      s4_fr_r     <= s3_fr_r;
      s4_push_r   <= s3_push_r;
      s4_sample_r <= s3_sample_r;
      s4_last_r   <= s3_last_r;
      s4_waddr_r  <= s3_waddr_r;
    end
  end

  // Stage 5: store write and both tap reads at the same edge
  always_comb begin
    st_wr.en     = ld5 && v4_r && s4_push_r;
    st_wr.addr   = s4_waddr_r;
    st_wr.data   = s4_sample_r;
    st_rd.en     = ld5 && v4_r;
    st_rd.addr_a = s4_ia_r;
    st_rd.addr_b = s4_ib_r;
  end

  mfd_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (st_wr),
    .rd    (st_rd),
    .rd_a  (smp_a),
    .rd_b  (smp_b)
  );

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_fr_r   <= s4_fr_r;
      s5_last_r <= s4_last_r;
    end
  end

  // Stage 6: weighted products
  assign one_m_fr = ONE - {1'b0, s5_fr_r};

  always_ff @(posedge clk) begin
    if (ld6) begin
      s6_pa_r   <= smp_a * $signed({1'b0, one_m_fr});
      s6_pb_r   <= smp_b * $signed({2'b00, s5_fr_r});
      s6_last_r <= s5_last_r;
    end
  end

  // Output stage: sum and drop fraction bits (floor)
  assign acc = mfd_pkg::ACC_W'(s6_pa_r) + mfd_pkg::ACC_W'(s6_pb_r);

  always_ff @(posedge clk) begin
    if (ld7) begin
      out_tap_r  <= acc[mfd_pkg::FRAC_BITS +: mfd_pkg::SAMPLE_W];
      out_last_r <= s6_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mfd_pkg::OUT_DATA_W'(out_tap_r);
  assign out_tlast  = out_last_r;

  // Write pointer always stays inside the active length
  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wp_r} < eff_len_r))
    else $error("write pointer outside delay line length");

  // Tap read addresses stay inside the active length
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (({1'b0, s4_ia_r} < eff_len_r) && ({1'b0, s4_ib_r} < eff_len_r)))
    else $error("tap read address outside delay line length");

  // A blocked product stage keeps its item
  a_s6_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && !ld7) |=> v6_r)
    else $error("product stage lost an item under stall");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multitap_fractional_delay_core. A behavioral model
// of the circular sample line predicts every interpolated tap. Each returned
// transaction is checked in order against the oldest prediction. Runs cover
// directed corner taps, length register extremes, random sample periods
// under random back-pressure, and a stretch with no idling on either side.
// ----------------------------------------------------------------------------
module testbench;

  // Request kinds carried on in_tuser
  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_PUSH = 1'b1;

  localparam int SETTLE_CYCLES = 12;    // pipeline is seven deep
  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int IDLE_PCT      = 15;

  typedef struct {
    mfd_pkg::sample_t tap;
    logic             last;
  } tap_result_t;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [mfd_pkg::IN_DATA_W-1:0]  in_tdata    = '0;   // [15:0] sample_in, [39:16] tap_delay
  logic                           in_tuser    = 1'b0; // [0] req_type
  logic                           in_tlast    = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [mfd_pkg::OUT_DATA_W-1:0] out_tdata;          // [15:0] tap_out
  logic                           out_tlast;
  logic                           cfg_wr_en   = 1'b0;
  logic [mfd_pkg::CFG_W-1:0]      cfg_wr_data = '0;

  // Model state: sample line, write head and length register
  mfd_pkg::sample_t          line_mem [mfd_pkg::DEPTH];
  int                        head_ptr;
  logic [mfd_pkg::CFG_W-1:0] len_reg;
  tap_result_t               pending_taps [$];
  tap_result_t               want;

  int  mismatches   = 0;
  int  taps_sent    = 0;
  int  taps_checked = 0;
  int  lengths_used = 0;
  int  quiet_cycles = 0;
  bit  steady       = 1'b0;

  always #5 clk = ~clk;

  multitap_fractional_delay_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Length actually used by the line: register clamped to [2, DEPTH]
  function automatic int active_len();
    int n;
    n = int'(len_reg);
    if (n < int'(mfd_pkg::MIN_LEN)) n = int'(mfd_pkg::MIN_LEN);
    if (n > mfd_pkg::DEPTH) n = mfd_pkg::DEPTH;
    return n;
  endfunction

  // Interpolated tap prediction for one accepted transaction
  function automatic void predict_tap(logic req, mfd_pkg::sample_t smp,
                                      logic [mfd_pkg::DELAY_W-1:0] dly, logic lst);
    int          n, span, dl, pos, ia, ib, fr;
    longint      acc;
    tap_result_t r;
    n    = active_len();
    span = n << mfd_pkg::FRAC_BITS;
    if (head_ptr >= n) head_ptr = 0;
    if (req == REQ_PUSH) begin
      line_mem[head_ptr] = smp;
      head_ptr = (head_ptr + 1 >= n) ? 0 : head_ptr + 1;
    end
    // long delays saturate at the line length
    dl = int'(dly);
    if (dl > span) dl = span;
    pos = (head_ptr << mfd_pkg::FRAC_BITS) - dl;
    if (pos < 0) pos += span;
    ia = pos >> mfd_pkg::FRAC_BITS;
    fr = pos & ((1 << mfd_pkg::FRAC_BITS) - 1);
    if (ia >= n) ia = 0;
    ib = (ia + 1 >= n) ? 0 : ia + 1;
    // full-precision blend, low bits dropped (floor)
    acc = longint'(line_mem[ia]) * longint'((1 << mfd_pkg::FRAC_BITS) - fr)
        + longint'(line_mem[ib]) * longint'(fr);
    r.tap  = mfd_pkg::sample_t'(acc >>> mfd_pkg::FRAC_BITS);
    r.last = lst;
    pending_taps.push_back(r);
  endfunction

  function automatic mfd_pkg::sample_t rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return mfd_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Mostly in-range delays, some full 24-bit and some around the line end
  function automatic logic [mfd_pkg::DELAY_W-1:0] rand_delay(int n);
    int top;
    top = n << mfd_pkg::FRAC_BITS;
    if (top > 'hFFFFFF) top = 'hFFFFFF;
    case ($urandom_range(9))
      7:       return mfd_pkg::DELAY_W'($urandom);
      8:       return mfd_pkg::DELAY_W'(top - 3 + int'($urandom_range(6)));
      9:       return mfd_pkg::DELAY_W'($urandom_range(511));
      default: return mfd_pkg::DELAY_W'($urandom_range(top));
    endcase
  endfunction

  // One input transaction, with random idle cycles ahead of it
  task automatic send_tap(input logic req, input mfd_pkg::sample_t smp,
                          input logic [mfd_pkg::DELAY_W-1:0] dly, input logic lst);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dly, smp};
    in_tuser  <= req;
    in_tlast  <= lst;
    do begin
      @(posedge clk);
    end while (!in_tready);
    predict_tap(req, smp, dly, lst);
    taps_sent++;
  endtask

  // Stop sending and wait until every predicted tap has come back
  task automatic drain_line();
    in_tvalid <= 1'b0;
    while (pending_taps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Length write, only with the line idle; the write head returns to zero
  task automatic set_length(input logic [mfd_pkg::CFG_W-1:0] v);
    drain_line();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_reg   = v;
    head_ptr  = 0;
    lengths_used++;
  endtask

  // Sample periods: one push, then read-only taps, last one flagged; some noise
  task automatic run_periods(input int n_items);
    int   done, taps, k;
    logic req, lst;
    done = 0;
    while (done < n_items) begin
      taps = $urandom_range(1, 4);
      for (k = 0; k < taps; k++) begin
        req = (k == 0) ? REQ_PUSH : REQ_READ;
        lst = (k == taps - 1);
        if ($urandom_range(99) < 10) begin
          req = logic'($urandom);
          lst = logic'($urandom);
        end
        send_tap(req, rand_sample(), rand_delay(active_len()), lst);
        done++;
      end
    end
  endtask

  // Corner taps at the reset length
  task automatic test_directed();
    send_tap(REQ_PUSH, 16'sh7FFF, 24'h000100, 1'b0);  // newest sample, no fraction
    send_tap(REQ_PUSH, 16'sh8000, 24'h000180, 1'b0);  // half blend, floors to -1
    send_tap(REQ_PUSH, 16'sh5555, 24'h0001FF, 1'b0);
    send_tap(REQ_PUSH, 16'shAAAA, 24'h0000FF, 1'b1);
    send_tap(REQ_READ, 16'sh0000, 24'h000000, 1'b0);  // oldest, never written
    send_tap(REQ_READ, 16'shFFFF, 24'hFFFFFF, 1'b0);  // saturates
    send_tap(REQ_READ, 16'sh1234, 24'hBB8100, 1'b0);  // exactly the length
    send_tap(REQ_READ, 16'sh0000, 24'hBB80FF, 1'b0);  // just under the length
    send_tap(REQ_READ, 16'sh0000, 24'h000400, 1'b0);  // first sample written, no fraction
    send_tap(REQ_READ, 16'sh0000, 24'h000280, 1'b1);
    send_tap(REQ_PUSH, 16'sh0000, 24'h000080, 1'b1);
    send_tap(REQ_PUSH, 16'shFFFF, 24'h000001, 1'b0);
  endtask

  // Length register extremes, including clamped values
  task automatic test_length_extremes();
    logic [mfd_pkg::CFG_W-1:0]   lens [7]   = '{0, 1, 2, 3, 65536, 131071, 65537};
    logic [mfd_pkg::DELAY_W-1:0] delays [8] = '{24'h000000, 24'h000080, 24'h000100,
                                                24'h000180, 24'h0001FF, 24'h0002FF,
                                                24'hFFFFFF, 24'h000200};
    int i, j;
    for (i = 0; i < 7; i++) begin
      set_length(lens[i]);
      for (j = 0; j < 8; j++)
        send_tap((j % 3 != 2) ? REQ_PUSH : REQ_READ, rand_sample(), delays[j], j == 7);
    end
  endtask

  // Random lengths and periods, with one full drain mid-stream
  task automatic test_random_lengths();
    int p;
    for (p = 0; p < 6; p++) begin
      if ($urandom_range(99) < 70) set_length(mfd_pkg::CFG_W'($urandom_range(2, 48)));
      else set_length(mfd_pkg::CFG_W'($urandom));
      run_periods(30);
      if (p == 2) drain_line();
      run_periods(10);
    end
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    set_length(mfd_pkg::CFG_W'($urandom_range(2, 32)));
    steady = 1'b1;
    run_periods(60);
    drain_line();
    steady = 1'b0;
  endtask

  // Full-size line with long random delays
  task automatic test_wide_line();
    set_length(mfd_pkg::CFG_W'(mfd_pkg::DEPTH));
    run_periods(40);
  endtask

  // Result checker and random back-pressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_taps.size() == 0) begin
        $error("unexpected tap result: tap_out %h last_flag %b", out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = pending_taps.pop_front();
        taps_checked++;
        if (out_tdata[mfd_pkg::SAMPLE_W-1:0] !== want.tap) begin
          $error("tap_out: expected %h, got %h", want.tap,
                 out_tdata[mfd_pkg::SAMPLE_W-1:0]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last_flag: expected %b, got %b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    foreach (line_mem[i]) line_mem[i] = '0;
    head_ptr = 0;
    len_reg  = mfd_pkg::CFG_W'(mfd_pkg::MAX_LEN_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_length_extremes();
    test_random_lengths();
    test_back_to_back();
    test_wide_line();
    drain_line();

    $display("covered %0d taps (%0d checked) over %0d line lengths,", taps_sent,
             taps_checked, lengths_used);
    $display("clamped lengths, saturated delays and wrap-around reads included");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
